### hw/rtl/zzr_pkg.sv
// Shared types and constants for the zigzag row reorder block.
package zzr_pkg;

    localparam int BYTE_W = 8;
    localparam int ROWS_W = 7;
    localparam int STEP_W = ROWS_W + 1;
    localparam int SUM_W  = ROWS_W + 2;

    typedef struct packed {
        logic en;
        logic last;
        logic ovf;
    } zzr_rd_t;

endpackage

### hw/rtl/zzr_mem.sv
// Message buffer: one write port, one read port with registered read data.
module zzr_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [zzr_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [zzr_pkg::BYTE_W-1:0] rd_data
);
    import zzr_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/zzr_seq.sv
// Load control and zigzag read address sequencer.
module zzr_seq #(
    parameter int MAX_LEN = 64,
    parameter int AW      = 6,
    parameter int CW      = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [zzr_pkg::ROWS_W-1:0] num_rows,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [zzr_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [zzr_pkg::BYTE_W-1:0] wr_data,
    output zzr_pkg::zzr_rd_t           rd,
    output logic [AW-1:0]              rd_addr,
    input  logic                       space
);
    import zzr_pkg::*;

    localparam int IW = (CW > SUM_W) ? CW : SUM_W;

    localparam logic ST_LOAD = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              drop_reg, drop_next;
    logic [CW-1:0]     len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [ROWS_W-1:0] r_reg, r_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              up_reg, up_next;

    logic              accept;
    logic              room;
    logic [STEP_W-1:0] period;
    logic [STEP_W-1:0] up_step;
    logic [STEP_W-1:0] step;
    logic              in_row;
    logic              is_last;

    assign accept  = in_valid && in_ready;
    assign in_ready = (state_reg == ST_LOAD);
    assign room    = (cnt_reg < CW'(MAX_LEN));

    assign wr_en   = accept && room;
    assign wr_addr = cnt_reg[AW-1:0];
    assign wr_data = in_byte;

    assign period  = {num_rows, 1'b0} - STEP_W'(2);
    assign up_step = {r_reg, 1'b0};
    assign in_row  = (idx_reg < IW'(len_reg));
    assign is_last = ((k_reg + CW'(1)) == len_reg);

    always_comb
    begin
        if (num_rows <= ROWS_W'(1))
        begin
            step = STEP_W'(1);
        end
        else if ((r_reg == '0) || (r_reg == (num_rows - ROWS_W'(1))))
        begin
            step = period;
        end
        else if (up_reg)
        begin
            step = up_step;
        end
        else
        begin
            step = period - up_step;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        idx_next   = idx_reg;
        up_next    = up_reg;
        rd.en      = 1'b0;
        rd.last    = is_last;
        rd.ovf     = ovf_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (room)
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        len_next   = room ? (cnt_reg + CW'(1)) : cnt_reg;
                        ovf_next   = drop_reg || !room;
                        k_next     = '0;
                        r_next     = '0;
                        idx_next   = '0;
                        up_next    = 1'b0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!in_row)
                begin
                    r_next   = r_reg + ROWS_W'(1);
                    idx_next = IW'(r_reg) + IW'(1);
                    up_next  = 1'b0;
                end
                else if (space)
                begin
                    rd.en    = 1'b1;
                    k_next   = k_reg + CW'(1);
                    idx_next = idx_reg + IW'(step);
                    up_next  = !up_reg;
                    if (is_last)
                    begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        ovf_reg <= ovf_next;
        k_reg   <= k_next;
        r_reg   <= r_next;
        idx_reg <= idx_next;
        up_reg  <= up_next;
    end

endmodule

### hw/rtl/zzr_outq.sv
// Two-word output queue fed by the buffer read port.
module zzr_outq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  zzr_pkg::zzr_rd_t           rd,
    input  logic [zzr_pkg::BYTE_W-1:0] rd_data,
    output logic                       space,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [zzr_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       overflow
);
    import zzr_pkg::*;

    logic              fly_reg;
    logic              fly_last_reg;
    logic              fly_ovf_reg;
    logic [1:0]        cnt_reg, cnt_next;
    logic              wp_reg;
    logic              rp_reg;
    logic [BYTE_W-1:0] byte_reg [2];
    logic [1:0]        last_reg;
    logic [1:0]        ovf_reg;
    logic              pop;
    logic [1:0]        used;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign used      = cnt_reg + {1'b0, fly_reg} - {1'b0, pop};
    assign space     = (used < 2'd2);

    assign out_byte  = byte_reg[rp_reg];
    assign out_last  = last_reg[rp_reg];
    assign overflow  = ovf_reg[rp_reg];

    assign cnt_next  = cnt_reg + {1'b0, fly_reg} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fly_reg <= 1'b0;
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            fly_reg <= rd.en;
            cnt_reg <= cnt_next;
            if (fly_reg)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            fly_last_reg <= rd.last;
            fly_ovf_reg  <= rd.ovf;
        end
        if (fly_reg)
        begin
            byte_reg[wp_reg] <= rd_data;
            last_reg[wp_reg] <= fly_last_reg;
            ovf_reg[wp_reg]  <= fly_ovf_reg;
        end
    end

endmodule

### hw/rtl/zigzag_row_reorder.sv
// Top level of the zigzag row reorder block.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, num_rows[6:0]     | in
//  in      | in_valid, in_ready, in_byte, in_last    | in
//  out     | out_valid, out_ready, out_byte,         | out
//          | out_last, overflow                      |
//
// Loading takes one word per cycle; only the first MAX_LEN are buffered.
// After the last word, emission reads the buffer once per word, with no read
// at a row change; a word passes the read data register, then a queue entry.
// Reset leaves num_rows at 1 and an empty buffer; no clearing pass is needed.
// A stalled output holds up to two words; reads pause when the queue is full,
// and no input word is taken until every read of the message has issued.
module zigzag_row_reorder #(
    parameter int MAX_LEN = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [zzr_pkg::ROWS_W-1:0] num_rows,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [zzr_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [zzr_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       overflow
);
    import zzr_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [ROWS_W-1:0] num_rows_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [BYTE_W-1:0] wr_data;
    zzr_rd_t           rd;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              space;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= ROWS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_rows_reg <= num_rows;
        end
    end

    zzr_seq #(
        .MAX_LEN (MAX_LEN),
        .AW      (AW),
        .CW      (CW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .num_rows (num_rows_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd       (rd),
        .rd_addr  (rd_addr),
        .space    (space)
    );

    zzr_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd.en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    zzr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd        (rd),
        .rd_data   (rd_data),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .overflow  (overflow)
    );

endmodule
